/* sv/ecpf_pkg.sv */
`default_nettype none
package ecpf_pkg;

  typedef struct packed {
    logic signed [31:0] in_density;
    logic signed [31:0] in_momentum_u;
    logic signed [31:0] in_momentum_v;
    logic signed [31:0] in_energy;
    logic signed [31:0] in_scalar;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_density;
    logic signed [31:0] out_momentum_u;
    logic signed [31:0] out_momentum_v;
    logic signed [31:0] out_energy;
    logic signed [31:0] out_scalar;
    logic               bad_density;
  } out_t;

  // side data that rides alongside the divider lanes
  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] energy;
    logic               bad;
  } side_t;

  typedef struct packed {
    logic [17:0] gamma_minus_one;
    logic [30:0] inv_gamma_minus_one;
    logic [30:0] density_floor;
    logic [30:0] pressure_floor;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_M1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA_M1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENS_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_FLOOR   = 3'd3;

  localparam int unsigned DIV_STEPS     = 32;
  localparam int unsigned DIV_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
  localparam int unsigned DIV_LAT       = DIV_STAGES + 2;
  localparam int unsigned REC_LAT       = 7;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = S32_MAX;
    else if (x < -64'sd2147483648) r = S32_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) r = x[32] ? S32_MIN : S32_MAX;
    else r = x[31:0];
    return r;
  endfunction

  // floor(a*b / 2^frac), saturated
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned frac);
    logic signed [63:0] p;
    p = a * b;
    return sat64(p >>> frac);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

endpackage
`default_nettype wire

/* sv/ecpf_div.sv */
`default_nettype none
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den), saturated.
// den must be positive; zero forces the result to zero.
module ecpf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                clk,
  input  wire                adv,
  input  wire signed [31:0]  num,
  input  wire        [31:0]  den,
  input  wire                zero,
  output logic signed [31:0] quo
);

  localparam int unsigned NST = ecpf_pkg::DIV_STAGES;

  logic [31:0] rem_r [NST+1];
  logic [31:0] nb_r  [NST+1];
  logic [31:0] q_r   [NST+1];
  logic [31:0] den_r [NST+1];
  logic        neg_r [NST+1];
  logic        ovf_r [NST+1];
  logic        zero_r[NST+1];
  logic signed [31:0] quo_r;

  logic [31:0] mag;
  logic [31:0] top_part;

  always_comb begin
    mag = num[31] ? (32'd0 - num) : num;
    top_part = mag >> (32 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= top_part;
      nb_r[0]   <= mag << FRAC_BITS;
      q_r[0]    <= '0;
      den_r[0]  <= den;
      neg_r[0]  <= num[31];
      ovf_r[0]  <= (top_part >= den);
      zero_r[0] <= zero;
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    logic [31:0] rem_nxt, nb_nxt, q_nxt;
    always_comb begin : step
      logic [32:0] t;
      rem_nxt = rem_r[k-1];
      nb_nxt  = nb_r[k-1];
      q_nxt   = q_r[k-1];
      for (int i = 0; i < ecpf_pkg::DIV_PER_STAGE; i++) begin
        t = {rem_nxt, nb_nxt[31]};
        nb_nxt = nb_nxt << 1;
        if (t >= {1'b0, den_r[k-1]}) begin
          t = t - {1'b0, den_r[k-1]};
          q_nxt = {q_nxt[30:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[30:0], 1'b0};
        end
        rem_nxt = t[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        nb_r[k]   <= nb_nxt;
        q_r[k]    <= q_nxt;
        den_r[k]  <= den_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  logic signed [31:0] quo_nxt;

  always_comb begin
    if (zero_r[NST]) quo_nxt = '0;
    else if (ovf_r[NST]) quo_nxt = neg_r[NST] ? ecpf_pkg::S32_MIN : ecpf_pkg::S32_MAX;
    else if (neg_r[NST])
      quo_nxt = (q_r[NST] > 32'h80000000) ? ecpf_pkg::S32_MIN : (32'd0 - q_r[NST]);
    else
      quo_nxt = (q_r[NST] > 32'h7fffffff) ? ecpf_pkg::S32_MAX : q_r[NST];
  end

  always_ff @(posedge clk) begin
    if (adv) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

/* sv/ecpf_recon.sv */
`default_nettype none
// Floor density and pressure, rebuild the conserved state.
module ecpf_recon #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  adv,
  input  wire signed [31:0]    vel_u,
  input  wire signed [31:0]    vel_v,
  input  wire signed [31:0]    spec,
  input  wire ecpf_pkg::side_t side,
  input  wire ecpf_pkg::cfg_t  cfg,
  output ecpf_pkg::out_t       res
);

  // stage 1
  logic signed [31:0] m1_r, m2_r, v1_r, v2_r, sp_r, rho_r, rf_r, en_r;
  logic               bad1_r;
  // stage 2
  logic signed [31:0] q_r, rho2_r, rf2_r, en2_r, mu_r, mv_r, so_r;
  logic               bad2_r;
  // stage 3
  logic signed [31:0] t1_r, t2_r, rf3_r, en3_r, mu3_r, mv3_r, so3_r;
  logic               bad3_r;
  // stage 4
  logic signed [31:0] df_r, t24_r, rf4_r, mu4_r, mv4_r, so4_r;
  logic               bad4_r;
  // stage 5
  logic signed [31:0] p_r, t25_r, rf5_r, mu5_r, mv5_r, so5_r;
  logic               bad5_r;
  // stage 6
  logic signed [31:0] e2_r, t26_r, rf6_r, mu6_r, mv6_r, so6_r;
  logic               bad6_r;
  // stage 7
  ecpf_pkg::out_t     res_r;

  logic signed [31:0] dfl, pfl, gm1, igm1, rf_nxt, pf_nxt;

  always_comb begin
    dfl  = {1'b0, cfg.density_floor};
    pfl  = {1'b0, cfg.pressure_floor};
    gm1  = {14'd0, cfg.gamma_minus_one};
    igm1 = {1'b0, cfg.inv_gamma_minus_one};
    rf_nxt = (side.density < dfl) ? dfl : side.density;
    pf_nxt = (p_r < pfl) ? pfl : p_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= ecpf_pkg::fx_mul(vel_u, vel_u, FRAC_BITS);
      m2_r   <= ecpf_pkg::fx_mul(vel_v, vel_v, FRAC_BITS);
      v1_r   <= vel_u;
      v2_r   <= vel_v;
      sp_r   <= spec[31] ? 32'sd0 : spec;
      rho_r  <= side.density;
      rf_r   <= rf_nxt;
      en_r   <= side.energy;
      bad1_r <= side.bad;

      q_r    <= ecpf_pkg::add_sat(m1_r, m2_r);
      rho2_r <= rho_r;
      rf2_r  <= rf_r;
      en2_r  <= en_r;
      mu_r   <= ecpf_pkg::fx_mul(rf_r, v1_r, FRAC_BITS);
      mv_r   <= ecpf_pkg::fx_mul(rf_r, v2_r, FRAC_BITS);
      so_r   <= ecpf_pkg::fx_mul(rf_r, sp_r, FRAC_BITS);
      bad2_r <= bad1_r;

      t1_r   <= ecpf_pkg::fx_mul(rho2_r, q_r, FRAC_BITS);
      t2_r   <= ecpf_pkg::fx_mul(rf2_r, q_r, FRAC_BITS);
      rf3_r  <= rf2_r;
      en3_r  <= en2_r;
      mu3_r  <= mu_r;
      mv3_r  <= mv_r;
      so3_r  <= so_r;
      bad3_r <= bad2_r;

      df_r   <= ecpf_pkg::sub_sat(en3_r, t1_r >>> 1);
      t24_r  <= t2_r;
      rf4_r  <= rf3_r;
      mu4_r  <= mu3_r;
      mv4_r  <= mv3_r;
      so4_r  <= so3_r;
      bad4_r <= bad3_r;

      p_r    <= ecpf_pkg::fx_mul(df_r, gm1, FRAC_BITS);
      t25_r  <= t24_r;
      rf5_r  <= rf4_r;
      mu5_r  <= mu4_r;
      mv5_r  <= mv4_r;
      so5_r  <= so4_r;
      bad5_r <= bad4_r;

      e2_r   <= ecpf_pkg::fx_mul(pf_nxt, igm1, FRAC_BITS);
      t26_r  <= t25_r;
      rf6_r  <= rf5_r;
      mu6_r  <= mu5_r;
      mv6_r  <= mv5_r;
      so6_r  <= so5_r;
      bad6_r <= bad5_r;

      res_r.out_density    <= rf6_r;
      res_r.out_momentum_u <= mu6_r;
      res_r.out_momentum_v <= mv6_r;
      res_r.out_energy     <= ecpf_pkg::add_sat(t26_r >>> 1, e2_r);
      res_r.out_scalar     <= so6_r;
      res_r.bad_density    <= bad6_r;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

/* sv/euler_cons_prim_floor.sv */
`default_nettype none
// Channel   Signals                            Beat
// input     in_valid/in_ready, in_data         one conserved cell
// output    out_valid/out_ready, out_data      one rebuilt cell + flag
// config    cfg_we, cfg_index, cfg_data        one register write
//
// One cell per cycle unless out_ready stalls; cells pass the divider lanes
// (8 stages of 4 restoring steps), then the rebuild multiplies.
// rst_n (synchronous) clears the valid chain, loads register defaults
// and holds in_ready low.
// The whole pipe advances when the output stage is empty or taken, so
// a stall on out_ready freezes every stage and holds in_ready low.
module euler_cons_prim_floor #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire ecpf_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ecpf_pkg::out_t                       out_data,
  input  wire                                  cfg_we,
  input  wire [ecpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [30:0]                           cfg_data
);

  localparam int unsigned LAT  = ecpf_pkg::DIV_LAT + ecpf_pkg::REC_LAT;
  localparam int unsigned DLAT = ecpf_pkg::DIV_LAT;

  ecpf_pkg::cfg_t  cfg_r;
  logic [LAT-1:0]  vld_r, vld_nxt;
  ecpf_pkg::side_t side_r [DLAT];
  logic            adv, bad;
  logic [31:0]     den;
  logic signed [31:0] vel_u, vel_v, spec;

  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv && rst_n;
  assign bad      = (in_data.in_density <= 32'sd0);
  assign den      = bad ? 32'd1 : in_data.in_density;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid & in_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gamma_minus_one     <= 18'd43691;
      cfg_r.inv_gamma_minus_one <= 31'd98304;
      cfg_r.density_floor       <= 31'd1;
      cfg_r.pressure_floor      <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        ecpf_pkg::CFG_GAMMA_M1:     cfg_r.gamma_minus_one     <= cfg_data[17:0];
        ecpf_pkg::CFG_INV_GAMMA_M1: cfg_r.inv_gamma_minus_one <= cfg_data;
        ecpf_pkg::CFG_DENS_FLOOR:   cfg_r.density_floor       <= cfg_data;
        ecpf_pkg::CFG_PRES_FLOOR:   cfg_r.pressure_floor      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  // side data shifts in step with the divider lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].density <= in_data.in_density;
      side_r[0].energy  <= in_data.in_energy;
      side_r[0].bad     <= bad;
      for (int i = 1; i < DLAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  ecpf_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk(clk), .adv(adv), .num(in_data.in_momentum_u), .den(den), .zero(bad), .quo(vel_u)
  );
  ecpf_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk(clk), .adv(adv), .num(in_data.in_momentum_v), .den(den), .zero(bad), .quo(vel_v)
  );
  ecpf_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
    .clk(clk), .adv(adv), .num(in_data.in_scalar), .den(den), .zero(bad), .quo(spec)
  );

  ecpf_recon #(.FRAC_BITS(FRAC_BITS)) u_recon (
    .clk(clk), .adv(adv), .vel_u(vel_u), .vel_v(vel_v), .spec(spec),
    .side(side_r[DLAT-1]), .cfg(cfg_r), .res(out_data)
  );

  assign out_valid = vld_r[LAT-1];

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_density |->
      out_data.out_momentum_u == 32'sd0 && out_data.out_momentum_v == 32'sd0 &&
      out_data.out_scalar == 32'sd0)
    else $error("bad density beat carries nonzero momentum or scalar");

  a_dens_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_density >= $signed({1'b0, cfg_r.density_floor}))
    else $error("density below floor");

  a_scalar_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.out_scalar[31])
    else $error("negative scalar");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid chain moved during stall");

endmodule
`default_nettype wire

/* test/tb_euler_cons_prim_floor.sv */
module tb_euler_cons_prim_floor;

  localparam int FRAC = 16;
  localparam int PIPE_LAT = 17;
  localparam longint CYCLE_LIMIT = 400000;
  // index that maps to no register
  localparam logic [ecpf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ecpf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ecpf_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [ecpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  euler_cons_prim_floor #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // limiter settings mirrored in the testbench
  longint gm1 = 43691, inv_gm1 = 98304, dens_min = 1, p_floor = 1;

  ecpf_pkg::in_t  cell_queue[$];
  ecpf_pkg::out_t limited_cells[$];
  int   errors = 0;
  bit   hold_send = 1'b0;
  longint cycles = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    return clamp32((a * (64'sd1 <<< FRAC)) / b);
  endfunction

  function automatic ecpf_pkg::out_t limit_cell(ecpf_pkg::in_t c);
    longint rho, v1, v2, s, q, ke, p, rf, pf;
    ecpf_pkg::out_t r;
    rho = c.in_density;
    v1 = 0; v2 = 0; s = 0;
    if (rho > 0) begin
      v1 = qdiv(c.in_momentum_u, rho);
      v2 = qdiv(c.in_momentum_v, rho);
      s = qdiv(c.in_scalar, rho);
    end
    q = clamp32(qmul(v1, v1) + qmul(v2, v2));
    ke = qmul(rho, q) >>> 1;
    p = qmul(clamp32(longint'(c.in_energy) - ke), gm1);
    rf = (rho < dens_min) ? dens_min : rho;
    pf = (p < p_floor) ? p_floor : p;
    if (s < 0) s = 0;
    r.out_density = rf[31:0];
    r.out_momentum_u = 32'(qmul(rf, v1));
    r.out_momentum_v = 32'(qmul(rf, v2));
    r.out_energy = 32'(clamp32((qmul(rf, q) >>> 1) + qmul(pf, inv_gm1)));
    r.out_scalar = 32'(qmul(rf, s));
    r.bad_density = (rho <= 0);
    return r;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        limited_cells.push_back(limit_cell(in_data));
      end
      if (!in_valid || in_ready) begin
        if (cell_queue.size() > 0 && !hold_send && gap_left == 0) begin
          in_data <= cell_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: own stall pattern, sometimes never stalling
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (limited_cells.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          errors++;
        end else begin
          ecpf_pkg::out_t e;
          e = limited_cells.pop_front();
          if (e != out_data) begin
            $display("%0t: mismatch exp %h act %h", $time, e, out_data);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (cycles % 7 < 4);
      endcase
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffff) : -$urandom_range(0, 32'h3ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic ecpf_pkg::in_t rnd_cell();
    ecpf_pkg::in_t c;
    c.in_density = ($urandom_range(0, 9) == 0) ? rnd_field() : $urandom_range(1, 32'h7ffff);
    c.in_momentum_u = rnd_field();
    c.in_momentum_v = rnd_field();
    c.in_energy = rnd_field();
    c.in_scalar = rnd_field();
    return c;
  endfunction

  // sample at the falling edge so every rising-edge update has settled
  task automatic wait_drained();
    while (cell_queue.size() > 0 || in_valid || limited_cells.size() > 0) @(negedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [ecpf_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ecpf_pkg::CFG_GAMMA_M1:     gm1 = val[17:0];
      ecpf_pkg::CFG_INV_GAMMA_M1: inv_gm1 = val;
      ecpf_pkg::CFG_DENS_FLOOR:   dens_min = val;
      ecpf_pkg::CFG_PRES_FLOOR:   p_floor = val;
      default: ;
    endcase
  endtask

  task automatic add_cell(logic [31:0] r, logic [31:0] u, logic [31:0] v,
                          logic [31:0] e, logic [31:0] s);
    ecpf_pkg::in_t c;
    c.in_density = r; c.in_momentum_u = u; c.in_momentum_v = v;
    c.in_energy = e; c.in_scalar = s;
    cell_queue.push_back(c);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, bad density, negative scalar, saturation
    add_cell(32'h00010000, 32'h00020000, 32'hfffe0000, 32'h00050000, 32'h00008000);
    add_cell(32'h0, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
    add_cell(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_cell(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_cell(32'h00000001, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    add_cell(32'h00010000, 32'h0, 32'h0, 32'h80000000, 32'hffff0000);
    add_cell(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_cell(32'h00000001, 32'h1, 32'h1, 32'h0, 32'h1);
    add_cell(32'h00100000, 32'h00400000, 32'h00400000, 32'h00001000, 32'h0);
    wait_drained();
    // zero density floor, zero gamma, extreme coefficients, bad register index
    write_reg(ecpf_pkg::CFG_DENS_FLOOR, 31'd0);
    write_reg(ecpf_pkg::CFG_GAMMA_M1, 31'd0);
    write_reg(ecpf_pkg::CFG_PRES_FLOOR, 31'h7fffffff);
    write_reg(ecpf_pkg::CFG_INV_GAMMA_M1, 31'h7fffffff);
    write_reg(CFG_IDX_SPARE, 31'h1234);
    add_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    add_cell(32'h00010000, 32'h00010000, 32'h0, 32'h00010000, 32'h00010000);
    add_cell(32'h80000000, 32'h0, 32'h0, 32'h7fffffff, 32'h0);
    for (int i = 0; i < 300; i++) cell_queue.push_back(rnd_cell());
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ecpf_pkg::CFG_GAMMA_M1, (ph == 0) ? 31'h3ffff : (ph == 1) ? 31'd1 :
                31'($urandom_range(1, 131072)));
      write_reg(ecpf_pkg::CFG_INV_GAMMA_M1, (ph == 1) ? 31'd1 :
                31'($urandom_range(1, 32'h7ffff)));
      write_reg(ecpf_pkg::CFG_DENS_FLOOR, (ph == 2) ? 31'h7fffffff :
                31'($urandom_range(0, 32'h20000)));
      write_reg(ecpf_pkg::CFG_PRES_FLOOR, (ph == 3) ? 31'd0 :
                31'($urandom_range(0, 32'h20000)));
      for (int i = 0; i < 275; i++) begin
        cell_queue.push_back(rnd_cell());
        if (i == 150) begin
          // pause the sender until the pipe has emptied
          while (cell_queue.size() > 0 || in_valid) @(negedge clk);
          hold_send = 1'b1;
          while (limited_cells.size() > 0) @(negedge clk);
          hold_send = 1'b0;
        end
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
